// ===== rtl/gnrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnrm_pkg
// Shared types, codes and reset values for the nub remapper with mouse output.
// ----------------------------------------------------------------------------
package gnrm_pkg;

    localparam int VALUE_W  = 16;
    localparam int DZ_W     = 15;
    localparam int SENS_W   = 10;
    localparam int MODE_W   = 4;
    localparam int CMODE_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_RES  = 5;
    localparam int CNT_W    = 3;

    // Motion scaling: p / 1000 == (p * RECIP) >> RECIP_SH for p < 2**PROD_W
    localparam int PROD_W   = 25;
    localparam int RECIP_SH = 35;
    localparam int RECIP_W  = 26;
    localparam logic [RECIP_W-1:0] RECIP = 26'd34359739;
    localparam int MUL_W    = PROD_W + RECIP_W;

    // input kinds
    localparam logic [1:0] KIND_AXIS  = 2'd0;
    localparam logic [1:0] KIND_CLICK = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // event types
    localparam logic [1:0] EV_ABS = 2'd0;
    localparam logic [1:0] EV_KEY = 2'd1;
    localparam logic [1:0] EV_REL = 2'd2;
    localparam logic [1:0] EV_SYN = 2'd3;

    // relative codes
    localparam logic [1:0] REL_X     = 2'd0;
    localparam logic [1:0] REL_Y     = 2'd1;
    localparam logic [1:0] REL_HSTEP = 2'd2;
    localparam logic [1:0] REL_VSTEP = 2'd3;

    // axis modes
    localparam logic [MODE_W-1:0] AXM_STICK_X  = 4'd1;
    localparam logic [MODE_W-1:0] AXM_STICK_RY = 4'd4;
    localparam logic [MODE_W-1:0] AXM_MOUSE_X  = 4'd5;
    localparam logic [MODE_W-1:0] AXM_MOUSE_Y  = 4'd6;
    localparam logic [MODE_W-1:0] AXM_PAN_H    = 4'd7;
    localparam logic [MODE_W-1:0] AXM_PAN_V    = 4'd8;

    // click modes
    localparam logic [CMODE_W-1:0] CLK_THUMB_L = 3'd1;
    localparam logic [CMODE_W-1:0] CLK_MOUSE_L = 3'd3;
    localparam logic [CMODE_W-1:0] CLK_MOUSE_R = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_MODES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_CLICK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_CLICK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_DZ     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_DZ    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SENS        = 3'd5;

    // reset values
    localparam logic [15:0]         RST_AXIS_MODES  = 16'h4321;
    localparam logic [CMODE_W-1:0]  RST_LEFT_CLICK  = 3'd1;
    localparam logic [CMODE_W-1:0]  RST_RIGHT_CLICK = 3'd2;
    localparam logic [DZ_W-1:0]     RST_MOVE_DZ     = 15'd100;
    localparam logic [DZ_W-1:0]     RST_WHEEL_DZ    = 15'd500;
    localparam logic [SENS_W-1:0]   RST_SENS        = 10'd15;

    typedef struct packed {
        logic [1:0]                kind;
        logic [1:0]                which;
        logic signed [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic mx_out;
        logic mx_neg;
        logic my_out;
        logic my_neg;
        logic sx_pos;
        logic sx_neg;
        logic sy_pos;
        logic sy_neg;
    } tick_flags_t;

    typedef struct packed {
        logic                      to_mouse;
        logic [1:0]                ev_type;
        logic [1:0]                ev_code;
        logic signed [VALUE_W-1:0] ev_value;
    } entry_t;

endpackage

// ===== rtl/gamepad_nub_remapper_with_mouse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_nub_remapper_with_mouse
// Maps nub axis and click requests to gamepad or mouse events; ticks emit
// scaled relative motion and wheel steps from the stored mouse/scroll levels.
// ----------------------------------------------------------------------------
// An accepted request passes stages r1 to r4, then its results are registered
//   in the result buffer that drives m_tvalid.
// Throughput: one input request per cycle through the four-stage pipe while
//   the pipe is not held; the result buffer sends one result per cycle (up to
//   5 for a tick) while m_tready is high, and holds the pipe until the last is taken.
// Motion scaling uses two registered multiplies (gain, then reciprocal of 1000).
// Reset (aresetn low, synchronous): registers to defaults, levels to zero,
//   pipeline and result buffer emptied.
module gamepad_nub_remapper_with_mouse (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] value
    input  logic [7:0]  s_tuser,   // [1:0] kind, [3:2] which, [7:4] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] event_value
    output logic [7:0]  m_tuser,   // [0] to_mouse, [2:1] event_type, [4:3] event_code
    output logic        m_tlast,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gnrm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gnrm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gnrm_pkg::*;

    // configuration
    logic [15:0]         axis_modes_reg;
    logic [CMODE_W-1:0]  left_click_reg;
    logic [CMODE_W-1:0]  right_click_reg;
    logic [DZ_W-1:0]     move_dz_reg;
    logic [DZ_W-1:0]     wheel_dz_reg;
    logic [SENS_W-1:0]   sens_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_modes_reg  <= RST_AXIS_MODES;
            left_click_reg  <= RST_LEFT_CLICK;
            right_click_reg <= RST_RIGHT_CLICK;
            move_dz_reg     <= RST_MOVE_DZ;
            wheel_dz_reg    <= RST_WHEEL_DZ;
            sens_reg        <= RST_SENS;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_AXIS_MODES:  axis_modes_reg  <= cfg_data;
                REG_LEFT_CLICK:  left_click_reg  <= cfg_data[CMODE_W-1:0];
                REG_RIGHT_CLICK: right_click_reg <= cfg_data[CMODE_W-1:0];
                REG_MOVE_DZ:     move_dz_reg     <= cfg_data[DZ_W-1:0];
                REG_WHEEL_DZ:    wheel_dz_reg    <= cfg_data[DZ_W-1:0];
                REG_SENS:        sens_reg        <= cfg_data[SENS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline registers
    logic                     r1_valid_reg, r2_valid_reg, r3_valid_reg, r4_valid_reg;
    item_t                    r1_item_reg, r2_item_reg, r3_item_reg, r4_item_reg;
    tick_flags_t              r2_flags_reg, r3_flags_reg, r4_flags_reg;
    logic [VALUE_W-1:0]       r2_magx_reg, r2_magy_reg;
    logic [PROD_W-1:0]        r3_px_reg, r3_py_reg;
    logic [VALUE_W-1:0]       r4_qx_reg, r4_qy_reg;

    // level state
    logic signed [VALUE_W-1:0] mouse_x_reg, mouse_y_reg, pan_h_reg, pan_v_reg;

    // result buffer
    logic                     list_valid_reg;
    entry_t                   list_reg [MAX_RES];
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         idx_reg;

    logic list_last, list_free;
    logic r1_adv, r2_adv, r3_adv, r4_adv;

    assign list_last = (idx_reg == (cnt_reg - CNT_W'(1)));
    assign list_free = !list_valid_reg || (m_tready && list_last);
    assign r4_adv    = r4_valid_reg && list_free;
    assign r3_adv    = r3_valid_reg && (!r4_valid_reg || r4_adv);
    assign r2_adv    = r2_valid_reg && (!r3_valid_reg || r3_adv);
    assign r1_adv    = r1_valid_reg && (!r2_valid_reg || r2_adv);
    assign s_tready  = !r1_valid_reg || r1_adv;

    // stage 1: level update, deadzone tests, distance magnitudes
    logic [MODE_W-1:0]         r1_mode;
    logic signed [VALUE_W:0]   mdz_s, wdz_s;
    logic signed [VALUE_W:0]   mx_s, my_s, sx_s, sy_s;
    logic signed [VALUE_W:0]   dx, dy, adx, ady;
    tick_flags_t               flags_next;

    assign r1_mode = axis_modes_reg[{r1_item_reg.which, 2'b00} +: MODE_W];
    assign mdz_s   = signed'({2'b00, move_dz_reg});
    assign wdz_s   = signed'({2'b00, wheel_dz_reg});
    assign mx_s    = {mouse_x_reg[VALUE_W-1], mouse_x_reg};
    assign my_s    = {mouse_y_reg[VALUE_W-1], mouse_y_reg};
    assign sx_s    = {pan_h_reg[VALUE_W-1], pan_h_reg};
    assign sy_s    = {pan_v_reg[VALUE_W-1], pan_v_reg};

    always_comb begin
        flags_next.mx_neg = (mx_s < -mdz_s);
        flags_next.mx_out = (mx_s > mdz_s) || flags_next.mx_neg;
        flags_next.my_neg = (my_s < -mdz_s);
        flags_next.my_out = (my_s > mdz_s) || flags_next.my_neg;
        flags_next.sx_pos = (sx_s > wdz_s);
        flags_next.sx_neg = (sx_s < -wdz_s);
        flags_next.sy_pos = (sy_s > wdz_s);
        flags_next.sy_neg = (sy_s < -wdz_s);
        dx  = flags_next.mx_neg ? (mx_s + mdz_s) : (mx_s - mdz_s);
        dy  = flags_next.my_neg ? (my_s + mdz_s) : (my_s - mdz_s);
        adx = flags_next.mx_neg ? -dx : dx;
        ady = flags_next.my_neg ? -dy : dy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mouse_x_reg <= '0;
            mouse_y_reg <= '0;
            pan_h_reg   <= '0;
            pan_v_reg   <= '0;
        end else if (r1_adv && (r1_item_reg.kind == KIND_AXIS)) begin
            unique case (r1_mode)
                AXM_MOUSE_X: mouse_x_reg <= r1_item_reg.value;
                AXM_MOUSE_Y: mouse_y_reg <= r1_item_reg.value;
                AXM_PAN_H:   pan_h_reg   <= r1_item_reg.value;
                AXM_PAN_V:   pan_v_reg   <= r1_item_reg.value;
                default: begin
                end
            endcase
        end
    end

    // stage 3 and 4 products
    logic [MUL_W-1:0] mulx, muly;
    assign mulx = MUL_W'(r3_px_reg) * MUL_W'(RECIP);
    assign muly = MUL_W'(r3_py_reg) * MUL_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
            r3_valid_reg <= 1'b0;
            r4_valid_reg <= 1'b0;
        end else begin
            if (s_tready) r1_valid_reg <= s_tvalid;
            if (!r2_valid_reg || r2_adv) r2_valid_reg <= r1_adv;
            if (!r3_valid_reg || r3_adv) r3_valid_reg <= r2_adv;
            if (!r4_valid_reg || r4_adv) r4_valid_reg <= r3_adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            r1_item_reg.kind  <= s_tuser[1:0];
            r1_item_reg.which <= s_tuser[3:2];
            r1_item_reg.value <= s_tdata;
        end
        if (r1_adv) begin
            r2_item_reg  <= r1_item_reg;
            r2_flags_reg <= flags_next;
            r2_magx_reg  <= adx[VALUE_W-1:0];
            r2_magy_reg  <= ady[VALUE_W-1:0];
        end
        if (r2_adv) begin
            r3_item_reg  <= r2_item_reg;
            r3_flags_reg <= r2_flags_reg;
            r3_px_reg    <= PROD_W'(r2_magx_reg) * PROD_W'(sens_reg);
            r3_py_reg    <= PROD_W'(r2_magy_reg) * PROD_W'(sens_reg);
        end
        if (r3_adv) begin
            r4_item_reg  <= r3_item_reg;
            r4_flags_reg <= r3_flags_reg;
            r4_qx_reg    <= mulx[MUL_W-1 -: VALUE_W];
            r4_qy_reg    <= muly[MUL_W-1 -: VALUE_W];
        end
    end

    // stage 5: sign, saturate and build the result list
    logic [VALUE_W-1:0] motx, moty;
    logic [MODE_W-1:0]  r4_mode;
    logic [CMODE_W-1:0] r4_cmode;
    entry_t             ents_next [MAX_RES];
    logic [CNT_W-1:0]   n_next;

    assign r4_mode  = axis_modes_reg[{r4_item_reg.which, 2'b00} +: MODE_W];
    assign r4_cmode = r4_item_reg.which[0] ? right_click_reg : left_click_reg;

    always_comb begin
        if (r4_flags_reg.mx_neg) begin
            motx = (r4_qx_reg > 16'h8000) ? 16'h8000 : (~r4_qx_reg + 16'd1);
        end else begin
            motx = (r4_qx_reg > 16'h7FFF) ? 16'h7FFF : r4_qx_reg;
        end
        if (r4_flags_reg.my_neg) begin
            moty = (r4_qy_reg > 16'h8000) ? 16'h8000 : (~r4_qy_reg + 16'd1);
        end else begin
            moty = (r4_qy_reg > 16'h7FFF) ? 16'h7FFF : r4_qy_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_RES; i++) begin
            ents_next[i] = '0;
        end
        n_next = '0;
        unique case (r4_item_reg.kind)
            KIND_AXIS: begin
                if (r4_mode >= AXM_STICK_X && r4_mode <= AXM_STICK_RY) begin
                    ents_next[0] = '{1'b0, EV_ABS, 2'(r4_mode - AXM_STICK_X),
                                     r4_item_reg.value};
                    ents_next[1] = '{1'b0, EV_SYN, 2'd0, '0};
                    n_next = CNT_W'(2);
                end
            end
            KIND_CLICK: begin
                if (!r4_item_reg.which[1] && r4_cmode >= CLK_THUMB_L &&
                    r4_cmode <= CLK_MOUSE_R) begin
                    ents_next[0] = '{(r4_cmode >= CLK_MOUSE_L), EV_KEY,
                                     2'(r4_cmode - CLK_THUMB_L), r4_item_reg.value};
                    ents_next[1] = '{(r4_cmode >= CLK_MOUSE_L), EV_SYN, 2'd0, '0};
                    n_next = CNT_W'(2);
                end
            end
            KIND_TICK: begin
                if (r4_flags_reg.mx_out || r4_flags_reg.my_out ||
                    r4_flags_reg.sx_pos || r4_flags_reg.sx_neg ||
                    r4_flags_reg.sy_pos || r4_flags_reg.sy_neg) begin
                    if (r4_flags_reg.mx_out) begin
                        ents_next[n_next] = '{1'b1, EV_REL, REL_X, motx};
                        n_next = n_next + CNT_W'(1);
                    end
                    if (r4_flags_reg.my_out) begin
                        ents_next[n_next] = '{1'b1, EV_REL, REL_Y, moty};
                        n_next = n_next + CNT_W'(1);
                    end
                    if (r4_flags_reg.sx_pos || r4_flags_reg.sx_neg) begin
                        ents_next[n_next] = '{1'b1, EV_REL, REL_HSTEP,
                                              r4_flags_reg.sx_pos ? 16'sd1 : -16'sd1};
                        n_next = n_next + CNT_W'(1);
                    end
                    if (r4_flags_reg.sy_pos || r4_flags_reg.sy_neg) begin
                        ents_next[n_next] = '{1'b1, EV_REL, REL_VSTEP,
                                              r4_flags_reg.sy_pos ? -16'sd1 : 16'sd1};
                        n_next = n_next + CNT_W'(1);
                    end
                    ents_next[n_next] = '{1'b1, EV_SYN, 2'd0, '0};
                    n_next = n_next + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // result buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_valid_reg <= 1'b0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
        end else if (list_free) begin
            list_valid_reg <= r4_adv && (n_next != '0);
            idx_reg        <= '0;
            if (r4_adv) cnt_reg <= n_next;
        end else if (m_tready) begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (r4_adv && list_free) begin
            for (int i = 0; i < MAX_RES; i++) begin
                list_reg[i] <= ents_next[i];
            end
        end
    end

    entry_t cur;
    assign cur      = list_reg[idx_reg];
    assign m_tvalid = list_valid_reg;
    assign m_tdata  = cur.ev_value;
    assign m_tuser  = {3'b000, cur.ev_code, cur.ev_type, cur.to_mouse};
    assign m_tlast  = list_last;

    // checks
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        list_valid_reg |-> (cnt_reg != '0) && (cnt_reg <= CNT_W'(MAX_RES)))
        else $error("result count out of range");

    a_idx_below_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        list_valid_reg |-> (idx_reg < cnt_reg))
        else $error("result index past count");

    a_sync_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((cur.ev_type == EV_SYN) == m_tlast))
        else $error("sync and last disagree");

    a_r4_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (r4_valid_reg && !list_free) |=> r4_valid_reg)
        else $error("stage 4 item dropped while buffer busy");

endmodule
